FILE: rtl/particle_integrate_step_macros.svh
// Assertion macros shared by the particle integrator RTL.
`ifndef PARTICLE_INTEGRATE_STEP_MACROS_SVH
`define PARTICLE_INTEGRATE_STEP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pit assertion failed");
// Next-cycle implication.
`define PIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pit assertion failed");
`else
`define PIT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PIT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/pit_pkg.sv
// Shared widths, constants and types for the particle integrator.
package pit_pkg;

  localparam int FRAC    = 16;
  localparam int POS_W   = 30;
  localparam int VEL_W   = 23;
  localparam int PSUM_W  = POS_W + 1;
  localparam int PROD_W  = VEL_W + FRAC + 1;
  localparam int M2_W    = 2 * VEL_W;
  localparam int SQ_N    = M2_W / 2;
  localparam int MAG_W   = VEL_W;
  localparam int QW      = FRAC + 2;
  localparam int NUM_W   = VEL_W + FRAC + 1;

  // configuration port
  localparam int WALL_W   = 12;
  localparam int MARGIN_W = 10;
  localparam int SPEED_W  = 24;
  localparam int PUSH_W   = SPEED_W - 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = SPEED_W;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_HEIGHT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MARGIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE   = CFG_IDX_W'(3);

  // data riding alongside the arithmetic stages
  typedef struct packed {
    logic [PSUM_W-1:0] px;
    logic [PSUM_W-1:0] py;
    logic [VEL_W-1:0]  vx;
    logic [VEL_W-1:0]  vy;
    logic              norm;
  } side_t;

endpackage

FILE: rtl/particle_integrate_step.sv
// Particle integrator top level: config registers, stall control, stage chain.
//
// Usage:
//   in_*   : one particle request (pos_x/pos_y Q13.16, vel_x/vel_y Q6.16, signed)
//            accepted when in_valid && in_ready.
//   out_*  : updated position and velocity, one result per request, in order,
//            taken when out_valid && out_ready.
//   cfg_*  : register writes (0 field_width, 1 field_height, 2 border_margin,
//            3 speed_scale); cfg_ready is always high, other indexes are dropped.
// Throughput: one request per cycle when not stalled. Stages: the square
//   root chain (23 stages, one root bit each) and the divider (18 stages, one
//   quotient bit each), plus 4 front stages and 3 wall/output stages.
// Stall: when out_valid is high and out_ready low, the whole chain holds and
//   in_ready drops; nothing is lost or repeated.
// Reset: valid bits clear and registers return to 1024, 768, 10, 1.0.
module particle_integrate_step (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pit_pkg::POS_W-1:0]      in_pos_x,
  input  logic signed [pit_pkg::POS_W-1:0]      in_pos_y,
  input  logic signed [pit_pkg::VEL_W-1:0]      in_vel_x,
  input  logic signed [pit_pkg::VEL_W-1:0]      in_vel_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pit_pkg::POS_W-1:0]      out_new_pos_x,
  output logic signed [pit_pkg::POS_W-1:0]      out_new_pos_y,
  output logic signed [pit_pkg::VEL_W-1:0]      out_new_vel_x,
  output logic signed [pit_pkg::VEL_W-1:0]      out_new_vel_y,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pit_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pit_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import pit_pkg::*;
  `include "particle_integrate_step_macros.svh"

  localparam int RECIP_SH = SPEED_W + 2;
  localparam logic [SPEED_W-1:0] RECIP5 = SPEED_W'(((64'd1 << RECIP_SH) + 4) / 5);
  localparam logic [MAG_W-1:0] MAG_MIN = MAG_W'(1) << FRAC;
  localparam logic [QW-1:0] QMAX = (QW'(1) << FRAC) + QW'(1);

  logic [WALL_W-1:0]   width_r, height_r;
  logic [MARGIN_W-1:0] margin_r;
  logic [SPEED_W-1:0]  speed_r;
  logic [PUSH_W-1:0]   push_r;
  logic [SPEED_W:0]    sp10;
  logic [2*SPEED_W-2:0] push_prod;
  logic                en;

  logic            fr_valid, sq_valid, dv_valid;
  side_t           fr_side, sq_side, dv_side;
  logic [M2_W-1:0] fr_m2;
  logic [MAG_W-1:0] sq_mag;
  logic [QW-1:0]   dv_qx, dv_qy;

  // config write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WALL_W'(1024);
      height_r <= WALL_W'(768);
      margin_r <= MARGIN_W'(10);
      speed_r  <= SPEED_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FIELD_WIDTH:   width_r  <= cfg_data[WALL_W-1:0];
        CFG_FIELD_HEIGHT:  height_r <= cfg_data[WALL_W-1:0];
        CFG_BORDER_MARGIN: margin_r <= cfg_data[MARGIN_W-1:0];
        CFG_SPEED_SCALE:   speed_r  <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // push = round(speed * 0.05) = floor(floor((speed + 10) / 4) / 5)
  assign sp10      = {1'b0, speed_r} + (SPEED_W+1)'(10);
  assign push_prod = (2*SPEED_W-1)'(sp10[SPEED_W:2]) * (2*SPEED_W-1)'(RECIP5);
  always_ff @(posedge clk) begin
    push_r <= push_prod[RECIP_SH +: PUSH_W];
  end

  // whole chain advances unless a result waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  pit_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid && in_ready),
    .pos_x_i (in_pos_x),
    .pos_y_i (in_pos_y),
    .vel_x_i (in_vel_x),
    .vel_y_i (in_vel_y),
    .valid_o (fr_valid),
    .side_o  (fr_side),
    .m2_o    (fr_m2)
  );

  pit_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (fr_valid),
    .side_i  (fr_side),
    .m2_i    (fr_m2),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .mag_o   (sq_mag)
  );

  pit_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (sq_valid),
    .side_i  (sq_side),
    .mag_i   (sq_mag),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .qx_o    (dv_qx),
    .qy_o    (dv_qy)
  );

  pit_wall u_wall (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_i  (dv_valid),
    .side_i   (dv_side),
    .qx_i     (dv_qx),
    .qy_i     (dv_qy),
    .width_i  (width_r),
    .height_i (height_r),
    .margin_i (margin_r),
    .push_i   (push_r),
    .valid_o  (out_valid),
    .pos_x_o  (out_new_pos_x),
    .pos_y_o  (out_new_pos_y),
    .vel_x_o  (out_new_vel_x),
    .vel_y_o  (out_new_vel_y)
  );

  // checks
  `PIT_ASSERT_IMP(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready, !in_ready)
  `PIT_ASSERT_IMP(a_mag_floor, clk, rst_n, sq_valid && sq_side.norm, sq_mag >= MAG_MIN)
  `PIT_ASSERT_IMP(a_quot_bound, clk, rst_n, dv_valid && dv_side.norm, (dv_qx <= QMAX) && (dv_qy <= QMAX))
  `PIT_ASSERT_NXT(a_hold_on_stall, clk, rst_n, !in_ready, $stable(dv_qx) && $stable(sq_mag))

endmodule

FILE: rtl/pit_front.sv
// Position advance, velocity damping and squared magnitude (four stages).
module pit_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 valid_i,
  input  logic signed [pit_pkg::POS_W-1:0]     pos_x_i,
  input  logic signed [pit_pkg::POS_W-1:0]     pos_y_i,
  input  logic signed [pit_pkg::VEL_W-1:0]     vel_x_i,
  input  logic signed [pit_pkg::VEL_W-1:0]     vel_y_i,
  output logic                                 valid_o,
  output pit_pkg::side_t                       side_o,
  output logic [pit_pkg::M2_W-1:0]             m2_o
);
  import pit_pkg::*;

  localparam int DAMP = ((98 << FRAC) + 50) / 100;
  localparam logic signed [PROD_W-1:0] DAMP_C = PROD_W'(DAMP);
  localparam logic [M2_W-1:0] ONE2 = M2_W'(1) << (2 * FRAC);

  // shift right by FRAC, round half away from zero
  function automatic logic [VEL_W-1:0] damp_round(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] a;
    logic [PROD_W-1:0] r;
    a = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    r = (a + (PROD_W'(1) << (FRAC - 1))) >> FRAC;
    damp_round = p[PROD_W-1] ? VEL_W'(-r) : VEL_W'(r);
  endfunction

  logic [3:0] vld_r;

  logic signed [PSUM_W-1:0] ps1x_r, ps1y_r, ps2x_r, ps2y_r, ps3x_r, ps3y_r;
  logic signed [PROD_W-1:0] prx_r, pry_r;
  logic [VEL_W-1:0]         vd2x_r, vd2y_r, vd3x_r, vd3y_r;
  logic [M2_W-1:0]          sqx_r, sqy_r;
  logic [VEL_W-1:0]         ax, ay;
  logic [M2_W-1:0]          m2_nxt;
  side_t                    side_r;
  logic [M2_W-1:0]          m2_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], valid_i};
    end
  end

  assign ax = vd2x_r[VEL_W-1] ? VEL_W'(-vd2x_r) : vd2x_r;
  assign ay = vd2y_r[VEL_W-1] ? VEL_W'(-vd2y_r) : vd2y_r;
  assign m2_nxt = sqx_r + sqy_r;

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      ps1x_r <= PSUM_W'(pos_x_i) + PSUM_W'(vel_x_i);
      ps1y_r <= PSUM_W'(pos_y_i) + PSUM_W'(vel_y_i);
      prx_r  <= PROD_W'(vel_x_i) * DAMP_C;
      pry_r  <= PROD_W'(vel_y_i) * DAMP_C;

      ps2x_r <= ps1x_r;
      ps2y_r <= ps1y_r;
      vd2x_r <= damp_round(prx_r);
      vd2y_r <= damp_round(pry_r);

      ps3x_r <= ps2x_r;
      ps3y_r <= ps2y_r;
      vd3x_r <= vd2x_r;
      vd3y_r <= vd2y_r;
      sqx_r  <= M2_W'(ax) * M2_W'(ax);
      sqy_r  <= M2_W'(ay) * M2_W'(ay);

      side_r.px   <= ps3x_r;
      side_r.py   <= ps3y_r;
      side_r.vx   <= vd3x_r;
      side_r.vy   <= vd3y_r;
      side_r.norm <= m2_nxt > ONE2;
      m2_r        <= m2_nxt;
    end
  end

  assign valid_o = vld_r[3];
  assign side_o  = side_r;
  assign m2_o    = m2_r;

endmodule

FILE: rtl/pit_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module pit_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  pit_pkg::side_t              side_i,
  input  logic [pit_pkg::M2_W-1:0]    m2_i,
  output logic                        valid_o,
  output pit_pkg::side_t              side_o,
  output logic [pit_pkg::MAG_W-1:0]   mag_o
);
  import pit_pkg::*;

  logic [M2_W-1:0] n_r    [SQ_N];
  logic [M2_W-1:0] root_r [SQ_N];
  side_t           side_r [SQ_N];
  logic [SQ_N-1:0] vld_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQ_N-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_st
    localparam logic [M2_W-1:0] BIT = M2_W'(1) << (2 * (SQ_N - 1 - k));
    logic [M2_W-1:0] n_in, root_in, trial;
    side_t           side_in;

    if (k == 0) begin : g_first
      assign n_in    = m2_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign n_in    = n_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial = root_in + BIT;

    // one restoring step
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_in;
        if (n_in >= trial) begin
          n_r[k]    <= n_in - trial;
          root_r[k] <= (root_in >> 1) + BIT;
        end else begin
          n_r[k]    <= n_in;
          root_r[k] <= root_in >> 1;
        end
      end
    end
  end

  assign valid_o = vld_r[SQ_N-1];
  assign side_o  = side_r[SQ_N-1];
  assign mag_o   = root_r[SQ_N-1][MAG_W-1:0];

endmodule

FILE: rtl/pit_div.sv
// Two-lane pipelined restoring divider: round(|v| * 2^FRAC / mag).
module pit_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  pit_pkg::side_t              side_i,
  input  logic [pit_pkg::MAG_W-1:0]   mag_i,
  output logic                        valid_o,
  output pit_pkg::side_t              side_o,
  output logic [pit_pkg::QW-1:0]      qx_o,
  output logic [pit_pkg::QW-1:0]      qy_o
);
  import pit_pkg::*;

  logic [MAG_W-1:0] rem_r [QW][2];
  logic [QW-1:0]    low_r [QW][2];
  logic [QW-1:0]    q_r   [QW][2];
  logic [MAG_W-1:0] mag_r [QW];
  side_t            side_r[QW];
  logic [QW-1:0]    vld_r;

  logic [VEL_W-1:0] vin [2];
  logic [VEL_W-1:0] av  [2];
  logic [NUM_W-1:0] num [2];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], valid_i};
    end
  end

  // rounded numerator per lane
  assign vin[0] = side_i.vx;
  assign vin[1] = side_i.vy;
  for (genvar l = 0; l < 2; l++) begin : g_num
    assign av[l]  = vin[l][VEL_W-1] ? VEL_W'(-vin[l]) : vin[l];
    assign num[l] = {1'b0, av[l], {FRAC{1'b0}}} + NUM_W'(mag_i >> 1);
  end

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [MAG_W-1:0] mag_in;
    side_t            side_in;

    if (k == 0) begin : g_first
      assign mag_in  = mag_i;
      assign side_in = side_i;
    end else begin : g_next
      assign mag_in  = mag_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[k]  <= mag_in;
        side_r[k] <= side_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [MAG_W-1:0] rem_in;
      logic [QW-1:0]    low_in, q_in;
      logic [MAG_W:0]   rs;
      logic             ge;

      if (k == 0) begin : g_first
        assign rem_in = {{(MAG_W-(NUM_W-QW)){1'b0}}, num[l][NUM_W-1:QW]};
        assign low_in = num[l][QW-1:0];
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = rem_r[k-1][l];
        assign low_in = low_r[k-1][l];
        assign q_in   = q_r[k-1][l];
      end

      assign rs = {rem_in, low_in[QW-1]};
      assign ge = rs >= {1'b0, mag_in};

      // one quotient bit
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l] <= ge ? MAG_W'(rs - {1'b0, mag_in}) : rs[MAG_W-1:0];
          low_r[k][l] <= low_in << 1;
          q_r[k][l]   <= {q_in[QW-2:0], ge};
        end
      end
    end
  end

  assign valid_o = vld_r[QW-1];
  assign side_o  = side_r[QW-1];
  assign qx_o    = q_r[QW-1][0];
  assign qy_o    = q_r[QW-1][1];

endmodule

FILE: rtl/pit_wall.sv
// Velocity select, wall push and reflection, saturation and output register.
module pit_wall (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               valid_i,
  input  pit_pkg::side_t                     side_i,
  input  logic [pit_pkg::QW-1:0]             qx_i,
  input  logic [pit_pkg::QW-1:0]             qy_i,
  input  logic [pit_pkg::WALL_W-1:0]         width_i,
  input  logic [pit_pkg::WALL_W-1:0]         height_i,
  input  logic [pit_pkg::MARGIN_W-1:0]       margin_i,
  input  logic [pit_pkg::PUSH_W-1:0]         push_i,
  output logic                               valid_o,
  output logic signed [pit_pkg::POS_W-1:0]   pos_x_o,
  output logic signed [pit_pkg::POS_W-1:0]   pos_y_o,
  output logic signed [pit_pkg::VEL_W-1:0]   vel_x_o,
  output logic signed [pit_pkg::VEL_W-1:0]   vel_y_o
);
  import pit_pkg::*;

  localparam int PW2 = PSUM_W + 2;
  localparam int VW2 = VEL_W + 2;

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [PW2-1:0] v);
    logic signed [PW2-1:0] hi, lo;
    hi = PW2'((64'sd1 <<< (POS_W - 1)) - 1);
    lo = -hi - PW2'(1);
    if (v > hi) sat_pos = POS_W'(hi);
    else if (v < lo) sat_pos = POS_W'(lo);
    else sat_pos = POS_W'(v);
  endfunction

  function automatic logic [VEL_W-1:0] sat_vel(input logic signed [VW2-1:0] v);
    logic signed [VW2-1:0] hi, lo;
    hi = VW2'((64'sd1 <<< (VEL_W - 1)) - 1);
    lo = -hi - VW2'(1);
    if (v > hi) sat_vel = VEL_W'(hi);
    else if (v < lo) sat_vel = VEL_W'(lo);
    else sat_vel = VEL_W'(v);
  endfunction

  logic [2:0] vld_r;

  logic [PSUM_W-1:0]     p1_r [2];
  logic signed [VEL_W-1:0] v1_r [2];
  logic signed [PW2-1:0] p2_r [2];
  logic signed [VW2-1:0] v2_r [2];
  logic [1:0]            flip_r;
  logic [POS_W-1:0]      pos_r [2];
  logic [VEL_W-1:0]      vel_r [2];

  logic [VEL_W-1:0]      vsel_nxt [2];
  logic signed [PW2-1:0] p2_nxt   [2];
  logic signed [VW2-1:0] v2_nxt   [2];
  logic [1:0]            flip_nxt;
  logic signed [VW2-1:0] v3_nxt   [2];

  logic [QW-1:0]         q    [2];
  logic [VEL_W-1:0]      vraw [2];
  logic [PSUM_W-1:0]     praw [2];
  logic [WALL_W-1:0]     wreg [2];
  logic signed [PW2-1:0] border_e;
  logic signed [VW2-1:0] push_e;

  assign q[0]    = qx_i;
  assign q[1]    = qy_i;
  assign vraw[0] = side_i.vx;
  assign vraw[1] = side_i.vy;
  assign praw[0] = side_i.px;
  assign praw[1] = side_i.py;
  assign wreg[0] = width_i;
  assign wreg[1] = height_i;
  assign border_e = $signed(PW2'({margin_i, {FRAC{1'b0}}}));
  assign push_e   = $signed(VW2'(push_i));

  // valid bits and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], valid_i};
    end
  end

  always_comb begin
    logic signed [PW2-1:0] p_e;
    logic signed [PW2-1:0] wall_e;
    logic signed [VW2-1:0] v_e;
    logic signed [VW2-1:0] vp;
    for (int l = 0; l < 2; l++) begin
      // normalized or damped velocity
      if (side_i.norm) begin
        vsel_nxt[l] = vraw[l][VEL_W-1] ? VEL_W'(-VEL_W'(q[l])) : VEL_W'(q[l]);
      end else begin
        vsel_nxt[l] = vraw[l];
      end

      // band push and mirror
      p_e    = PW2'($signed(p1_r[l]));
      wall_e = $signed(PW2'({wreg[l], {FRAC{1'b0}}}));
      v_e    = VW2'(v1_r[l]);
      p2_nxt[l]   = p_e;
      v2_nxt[l]   = v_e;
      flip_nxt[l] = 1'b0;
      if (p_e < border_e) begin
        v2_nxt[l] = v_e + push_e;
        if (p_e < 0) begin
          p2_nxt[l]   = -p_e;
          flip_nxt[l] = 1'b1;
        end
      end else if (p_e > wall_e - border_e) begin
        v2_nxt[l] = v_e - push_e;
        if (p_e > wall_e) begin
          p2_nxt[l]   = (wall_e <<< 1) - p_e;
          flip_nxt[l] = 1'b1;
        end
      end

      // on a mirror, scale by -0.5, halves rounded away from zero
      vp = v2_r[l];
      if (!flip_r[l]) begin
        v3_nxt[l] = vp;
      end else if (vp[VW2-1]) begin
        v3_nxt[l] = (-vp + VW2'(1)) >>> 1;
      end else begin
        v3_nxt[l] = -((vp + VW2'(1)) >>> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        p1_r[l]  <= praw[l];
        v1_r[l]  <= vsel_nxt[l];
        p2_r[l]  <= p2_nxt[l];
        v2_r[l]  <= v2_nxt[l];
        pos_r[l] <= sat_pos(p2_r[l]);
        vel_r[l] <= sat_vel(v3_nxt[l]);
      end
      flip_r <= flip_nxt;
    end
  end

  assign valid_o = vld_r[2];
  assign pos_x_o = pos_r[0];
  assign pos_y_o = pos_r[1];
  assign vel_x_o = vel_r[0];
  assign vel_y_o = vel_r[1];

endmodule

FILE: verif/particle_integrate_step_tb.sv
// Testbench for the particle integrator: random and directed particles, scoreboard check.
module particle_integrate_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pit_pkg::*;

  localparam int LATENCY_WAIT = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(9);

  typedef struct {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [VEL_W-1:0] vel_x;
    logic [VEL_W-1:0] vel_y;
  } particle_t;

  // Predicts the integrator's output and holds results still owed by the block
  class particle_scoreboard;
    longint unsigned wall_x, wall_y, margin, speed;
    particle_t owed_q[$];
    int accepted;
    int mismatches;

    function new();
      wall_x = 1024; wall_y = 768; margin = 10; speed = 65536;
      accepted = 0; mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FIELD_WIDTH:   wall_x = data[WALL_W-1:0];
        CFG_FIELD_HEIGHT:  wall_y = data[WALL_W-1:0];
        CFG_BORDER_MARGIN: margin = data[MARGIN_W-1:0];
        CFG_SPEED_SCALE:   speed = data[SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // round to nearest, ties away from zero
    function longint round_shift(longint v, int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v < 0) return -(((-v) + half) >>> s);
      return (v + half) >>> s;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, b;
      root = 0;
      b = longint'(1) << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= root + b) begin
          n = n - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    function longint norm_div(longint v, longint unsigned d);
      longint unsigned a, q;
      a = (v < 0) ? longint'(-v) : longint'(v);
      q = ((a << FRAC) + d / 2) / d;
      return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) << (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // border push and single mirror on one axis
    function void wall_bounce(ref longint p, ref longint v, input longint unsigned wreg,
                              input longint push);
      longint border, wall;
      border = longint'(margin << FRAC);
      wall = longint'(wreg << FRAC);
      if (p < border) begin
        v += push;
        if (p < 0) begin
          p = -p;
          v = -round_shift(v, 1);
        end
      end else if (p > wall - border) begin
        v -= push;
        if (p > wall) begin
          p = 2 * wall - p;
          v = -round_shift(v, 1);
        end
      end
    endfunction

    function void note_request(particle_t req);
      longint px, py, vx, vy, damp, push;
      longint unsigned m2, mag;
      particle_t res;
      px = longint'(signed'(req.pos_x));
      py = longint'(signed'(req.pos_y));
      vx = longint'(signed'(req.vel_x));
      vy = longint'(signed'(req.vel_y));
      damp = ((longint'(98) << FRAC) + 50) / 100;
      push = longint'((speed * 5 + 50) / 100);
      px += vx;
      py += vy;
      vx = round_shift(vx * damp, FRAC);
      vy = round_shift(vy * damp, FRAC);
      m2 = vx * vx + vy * vy;
      if (m2 > (longint'(1) << (2 * FRAC))) begin
        mag = int_sqrt(m2);
        vx = norm_div(vx, mag);
        vy = norm_div(vy, mag);
      end
      wall_bounce(px, vx, wall_x, push);
      wall_bounce(py, vy, wall_y, push);
      res.pos_x = POS_W'(clamp(px, POS_W));
      res.pos_y = POS_W'(clamp(py, POS_W));
      res.vel_x = VEL_W'(clamp(vx, VEL_W));
      res.vel_y = VEL_W'(clamp(vy, VEL_W));
      owed_q.push_back(res);
      accepted++;
    endfunction

    function void check_result(particle_t got);
      particle_t exp_r;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result with nothing owed");
        return;
      end
      exp_r = owed_q.pop_front();
      if (got.pos_x !== exp_r.pos_x || got.pos_y !== exp_r.pos_y ||
          got.vel_x !== exp_r.vel_x || got.vel_y !== exp_r.vel_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp pos %h %h vel %h %h, got pos %h %h vel %h %h",
                   exp_r.pos_x, exp_r.pos_y, exp_r.vel_x, exp_r.vel_y,
                   got.pos_x, got.pos_y, got.vel_x, got.vel_y);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0;
  logic signed [VEL_W-1:0] in_vel_x = '0, in_vel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POS_W-1:0] out_new_pos_x, out_new_pos_y;
  logic signed [VEL_W-1:0] out_new_vel_x, out_new_vel_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  particle_scoreboard sb = new();
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  particle_integrate_step u_top (.*);

  always #1 clk = ~clk;

  // idle-free window on both sides
  function automatic bit quiet_window();
    return sb.accepted >= 600 && sb.accepted < 760;
  endfunction

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** particle_integrate_step: FAILED **");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    particle_t got;
    if (rst_n && out_valid && out_ready) begin
      got.pos_x = out_new_pos_x;
      got.pos_y = out_new_pos_y;
      got.vel_x = out_new_vel_x;
      got.vel_y = out_new_vel_y;
      sb.check_result(got);
    end
  end

  // receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (!hold_done && sb.accepted >= 400) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_window() || ($urandom_range(99) >= 13);
    end
  end

  task automatic send_request(particle_t p);
    @(negedge clk);
    in_valid <= 1'b1;
    in_pos_x <= p.pos_x;
    in_pos_y <= p.pos_y;
    in_vel_x <= p.vel_x;
    in_vel_y <= p.vel_y;
    do @(posedge clk); while (!in_ready);
    sb.note_request(p);
    // random sender gap of one cycle
    if (!quiet_window() && $urandom_range(99) < 13) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic particle_t mk(longint px, longint py, longint vx, longint vy);
    particle_t p;
    p.pos_x = POS_W'(px); p.pos_y = POS_W'(py);
    p.vel_x = VEL_W'(vx); p.vel_y = VEL_W'(vy);
    return p;
  endfunction

  // position biased toward the walls and bands of one axis
  function automatic longint rand_pos(longint unsigned wreg);
    longint span;
    span = longint'((sb.margin + 8) << FRAC);
    case ($urandom_range(5))
      0: return longint'(signed'(POS_W'($urandom)));
      1: return longint'($urandom_range(0, 32'(2 * span))) - span;
      2: return longint'(wreg << FRAC) + longint'($urandom_range(0, 32'(2 * span))) - span;
      3: return longint'($urandom_range(0, 32'((wreg << FRAC) + 1)));
      default: return longint'($urandom_range(0, 1 << 18)) - (1 << 17);
    endcase
  endfunction

  function automatic longint rand_vel();
    case ($urandom_range(3))
      0: return longint'(signed'(VEL_W'($urandom)));
      1: return longint'($urandom_range(0, 1 << 18)) - (1 << 17);
      default: return longint'($urandom_range(0, 1 << 17)) - (1 << 16);
    endcase
  endfunction

  initial begin
    longint pmax, pmin, vmax, vmin;
    pmax = (longint'(1) << (POS_W - 1)) - 1;
    pmin = -pmax - 1;
    vmax = (longint'(1) << (VEL_W - 1)) - 1;
    vmin = -vmax - 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, bands, mirrors, normalization edge
    send_request(mk(0, 0, 0, 0));
    send_request(mk(pmax, pmax, vmax, vmax));
    send_request(mk(pmin, pmin, vmin, vmin));
    send_request(mk(pmax, pmin, vmin, vmax));
    send_request(mk(100 << FRAC, 100 << FRAC, 66871, 0));
    send_request(mk(100 << FRAC, 100 << FRAC, 46341, 46341));
    send_request(mk(5 << FRAC, 300 << FRAC, 1000, -2000));
    send_request(mk(-(3 << FRAC), -(1 << FRAC), -(1 << 15), 7));
    send_request(mk(1020 << FRAC, 765 << FRAC, 20000, 20000));
    send_request(mk(1030 << FRAC, 770 << FRAC, 1 << 16, -(1 << 16)));
    send_request(mk(-(400 << FRAC), 3000 << FRAC, -5, 5));
    send_request(mk(10 << FRAC, 758 << FRAC, 0, 0));
    send_request(mk(1, -1, 1, -1));
    end_burst();
    drain();

    // every register at its maximum, out-of-range index, truncated data
    write_reg(CFG_FIELD_WIDTH, 24'hFFFFFF);
    write_reg(CFG_FIELD_HEIGHT, 24'hFFF);
    write_reg(CFG_BORDER_MARGIN, 24'hFFFFFF);
    write_reg(CFG_SPEED_SCALE, 24'hFFFFFF);
    write_reg(CFG_UNUSED_IDX, 24'h000001);
    send_request(mk(-(2 << FRAC), 4094 << FRAC, 3 << 16, -(3 << 16)));
    send_request(mk(2000 << FRAC, 4100 << FRAC, vmax, vmin));
    send_request(mk(pmax, pmin, 0, 0));
    end_burst();
    drain();

    // zero walls, no margin, no push
    write_reg(CFG_FIELD_WIDTH, CFG_DATA_W'(0));
    write_reg(CFG_FIELD_HEIGHT, CFG_DATA_W'(0));
    write_reg(CFG_BORDER_MARGIN, CFG_DATA_W'(0));
    write_reg(CFG_SPEED_SCALE, CFG_DATA_W'(0));
    send_request(mk(1 << FRAC, -(1 << FRAC), 100, -100));
    send_request(mk(0, 0, 0, 0));
    send_request(mk(pmax, pmin, vmax, vmin));
    end_burst();
    drain();

    // random phases, each with fresh register settings
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        write_reg(CFG_FIELD_WIDTH, CFG_DATA_W'(1));
        write_reg(CFG_FIELD_HEIGHT, CFG_DATA_W'(1));
        write_reg(CFG_BORDER_MARGIN, CFG_DATA_W'(1));
        write_reg(CFG_SPEED_SCALE, CFG_DATA_W'(1));
      end else begin
        write_reg(CFG_FIELD_WIDTH, CFG_DATA_W'($urandom_range(1, 4095)));
        write_reg(CFG_FIELD_HEIGHT, CFG_DATA_W'($urandom_range(1, 4095)));
        write_reg(CFG_BORDER_MARGIN, CFG_DATA_W'($urandom_range(0, 1023)));
        write_reg(CFG_SPEED_SCALE, CFG_DATA_W'($urandom));
      end
      for (int i = 0; i < 180; i++)
        send_request(mk(rand_pos(sb.wall_x), rand_pos(sb.wall_y), rand_vel(), rand_vel()));
      end_burst();
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("** particle_integrate_step: PASSED **");
    end else begin
      $display("** particle_integrate_step: FAILED **");
    end
    $finish;
  end
endmodule
